/* design/qrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  // Default number of fraction bits in the coefficients and results.
  localparam int FRAC_BITS_DEF = 16;

  // Width of the tolerance register.
  localparam int TOL_W = 31;

  // Kind of solution reported with each result.
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_LINEAR  = 3'd1,
    KIND_TWO     = 3'd2,
    KIND_REPEAT  = 3'd3,
    KIND_COMPLEX = 3'd4
  } kind_t;

  // Coefficients and solution kind that travel down the pipeline.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    kind_t              kind;
  } ctx_t;

  // Result fields carried through the residual check stages.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               sat;
  } res_t;

endpackage

/* design/qrs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a tag that follows the data.
module qrs_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 33,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] out_tag
);

  // Each stage holds the shifting numerator, which fills with quotient bits from the right.
  logic [NUM_W-1:0] st_qn  [1:NUM_W];
  logic [DEN_W-1:0] st_rem [1:NUM_W];
  logic [DEN_W-1:0] st_den [1:NUM_W];
  logic [TAG_W-1:0] st_tag [1:NUM_W];
  logic             st_vld [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] qn_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             take;

    if (k == 0) begin : g_first
      assign qn_in  = num;
      assign rem_in = '0;
      assign den_in = den;
      assign tag_in = tag;
      assign vld_in = in_vld;
    end else begin : g_next
      assign qn_in  = st_qn[k];
      assign rem_in = st_rem[k];
      assign den_in = st_den[k];
      assign tag_in = st_tag[k];
      assign vld_in = st_vld[k];
    end

    // Bring down the next numerator bit and try to subtract the divisor.
    always_comb begin
      rem_sh  = {rem_in, qn_in[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_in};
      take    = (rem_sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k+1] <= 1'b0;
      end else begin
        st_vld[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      st_qn[k+1]  <= {qn_in[NUM_W-2:0], take};
      st_rem[k+1] <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      st_den[k+1] <= den_in;
      st_tag[k+1] <= tag_in;
    end
  end

  assign out_vld = st_vld[NUM_W];
  assign quot    = st_qn[NUM_W];
  assign out_tag = st_tag[NUM_W];

endmodule

/* design/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// Top level of the pipelined quadratic root solver.
//
// Usage: drive coef_a, coef_b and coef_c (signed, FRAC_BITS fraction bits) and
// raise start for one cycle per request. busy is always low, so a request is
// taken in every cycle that start is high, back to back without gaps.
// Each request gives one result: done is high for exactly one cycle with
// root_kind, first_value, second_value, the two check flags and saturated.
// The receiver cannot stall the block and must take the result in that cycle.
// Throughput is one request per cycle. The pipeline depth is set by the 33 stage
// square root pipeline and the restoring dividers, which retire one quotient bit
// per stage over 35 + FRAC_BITS stages; the residual check adds stages c1 to c4
// and the output registers.
// The user must write the tolerance through cfg_write and cfg_data only while no
// request is in flight; the block itself does not enforce this. Reset clears all
// valid bits, so no stale result appears, and sets the tolerance to one.
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         coef_a,
  input  logic signed [31:0]         coef_b,
  input  logic signed [31:0]         coef_c,
  input  logic                       cfg_write,
  input  logic [qrs_pkg::TOL_W-1:0]  cfg_data,
  output logic                       done,
  output logic [2:0]                 root_kind,
  output logic signed [31:0]         first_value,
  output logic signed [31:0]         second_value,
  output logic                       first_check_failed,
  output logic                       second_check_failed,
  output logic                       saturated
);

  localparam int SQ_N  = 33;
  localparam int OP_W  = 2 * SQ_N;
  localparam int REM_W = SQ_N + 4;
  localparam int NUM_W = 35 + FRAC_BITS;
  localparam int DEN_W = 33;
  localparam int RW    = 96;
  localparam int CTX_W = $bits(qrs_pkg::ctx_t);
  localparam int LAT   = 46 + NUM_W;

  // The pipeline takes a request in every cycle.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Tolerance register.
  logic [qrs_pkg::TOL_W-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= qrs_pkg::TOL_W'(1);
    end else if (cfg_write) begin
      tol <= cfg_data;
    end
  end

  // Stage 1: square of |b| and the product a*c.
  logic              s1_vld;
  qrs_pkg::ctx_t     s1_ctx;
  logic              s1_az;
  logic              s1_bz;
  logic [63:0]       s1_bb;
  logic signed [63:0] s1_ac;
  logic [31:0]       in_bmag;

  assign in_bmag = coef_b[31] ? -coef_b : coef_b;

  always_ff @(posedge clk) begin
    s1_ctx.a    <= coef_a;
    s1_ctx.b    <= coef_b;
    s1_ctx.c    <= coef_c;
    s1_ctx.kind <= qrs_pkg::KIND_NONE;
    s1_az       <= (coef_a == '0);
    s1_bz       <= (coef_b == '0);
    s1_bb       <= in_bmag * in_bmag;
    s1_ac       <= coef_a * coef_c;
  end

  // Stage 2: discriminant, exact.
  logic               s2_vld;
  qrs_pkg::ctx_t      s2_ctx;
  logic               s2_az;
  logic               s2_bz;
  logic signed [66:0] s2_d;

  always_ff @(posedge clk) begin
    s2_ctx <= s1_ctx;
    s2_az  <= s1_az;
    s2_bz  <= s1_bz;
    s2_d   <= $signed({3'b000, s1_bb}) - (67'(s1_ac) <<< 2);
  end

  // Stage 3: classify and take the magnitude of the discriminant.
  logic              s3_vld;
  qrs_pkg::ctx_t     s3_ctx;
  logic [OP_W-1:0]   s3_dmag;
  qrs_pkg::kind_t    s3_kind;

  always_comb begin
    priority if (s2_az && s2_bz) begin
      s3_kind = qrs_pkg::KIND_NONE;
    end else if (s2_az) begin
      s3_kind = qrs_pkg::KIND_LINEAR;
    end else if (s2_d[66]) begin
      s3_kind = qrs_pkg::KIND_COMPLEX;
    end else if (s2_d == '0) begin
      s3_kind = qrs_pkg::KIND_REPEAT;
    end else begin
      s3_kind = qrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctx      <= s2_ctx;
    s3_ctx.kind <= s3_kind;
    s3_dmag     <= s2_d[66] ? OP_W'(-s2_d) : OP_W'(s2_d);
  end

  // Square root pipeline, one root bit per stage.
  logic [OP_W-1:0]  sq_op   [1:SQ_N];
  logic [REM_W-1:0] sq_rem  [1:SQ_N];
  logic [SQ_N-1:0]  sq_root [1:SQ_N];
  qrs_pkg::ctx_t    sq_ctx  [1:SQ_N];
  logic             sq_vld  [1:SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [OP_W-1:0]  op_in;
    logic [REM_W-1:0] rem_in;
    logic [SQ_N-1:0]  root_in;
    qrs_pkg::ctx_t    ctx_in;
    logic             vld_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign op_in   = s3_dmag;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = s3_ctx;
      assign vld_in  = s3_vld;
    end else begin : g_next
      assign op_in   = sq_op[k];
      assign rem_in  = sq_rem[k];
      assign root_in = sq_root[k];
      assign ctx_in  = sq_ctx[k];
      assign vld_in  = sq_vld[k];
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], op_in[OP_W-1 -: 2]};
      trial  = {{(REM_W-SQ_N-2){1'b0}}, root_in, 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_op[k+1]   <= {op_in[OP_W-3:0], 2'b00};
      sq_rem[k+1]  <= take ? rem_sh - trial : rem_sh;
      sq_root[k+1] <= {root_in[SQ_N-2:0], take};
      sq_ctx[k+1]  <= ctx_in;
    end
  end

  // Prep stage 1: the two numerators -b + s and -b - s.
  logic               p1_vld;
  qrs_pkg::ctx_t      p1_ctx;
  logic [SQ_N-1:0]    p1_s;
  logic signed [34:0] p1_n1;
  logic signed [34:0] p1_n2;

  always_ff @(posedge clk) begin
    p1_ctx <= sq_ctx[SQ_N];
    p1_s   <= sq_root[SQ_N];
    p1_n1  <= $signed({2'b00, sq_root[SQ_N]}) - 35'(sq_ctx[SQ_N].b);
    p1_n2  <= -35'(sq_ctx[SQ_N].b) - $signed({2'b00, sq_root[SQ_N]});
  end

  // Prep stage 2: magnitudes, divisor and signs for each kind.
  logic               p2_vld;
  qrs_pkg::ctx_t      p2_ctx;
  logic [33:0]        p2_m1;
  logic [33:0]        p2_m2;
  logic [DEN_W-1:0]   p2_den;
  logic               p2_neg1;
  logic               p2_neg2;
  logic [31:0]        amag;
  logic [31:0]        bmag;
  logic [31:0]        cmag;
  logic [34:0]        n1mag;
  logic [34:0]        n2mag;
  logic               b_pos;
  logic               c_pos;
  logic [33:0]        m1;
  logic [33:0]        m2;
  logic [DEN_W-1:0]   den;
  logic               neg1;
  logic               neg2;

  always_comb begin
    amag  = p1_ctx.a[31] ? -p1_ctx.a : p1_ctx.a;
    bmag  = p1_ctx.b[31] ? -p1_ctx.b : p1_ctx.b;
    cmag  = p1_ctx.c[31] ? -p1_ctx.c : p1_ctx.c;
    n1mag = p1_n1[34] ? -p1_n1 : p1_n1;
    n2mag = p1_n2[34] ? -p1_n2 : p1_n2;
    b_pos = !p1_ctx.b[31] && (p1_ctx.b != '0);
    c_pos = !p1_ctx.c[31] && (p1_ctx.c != '0);
    unique case (p1_ctx.kind)
      qrs_pkg::KIND_LINEAR: begin
        m1   = 34'(cmag);
        m2   = '0;
        den  = {1'b0, bmag};
        neg1 = (c_pos != p1_ctx.b[31]);
        neg2 = 1'b0;
      end
      qrs_pkg::KIND_TWO: begin
        m1   = n1mag[33:0];
        m2   = n2mag[33:0];
        den  = {amag, 1'b0};
        neg1 = (p1_n1[34] != p1_ctx.a[31]);
        neg2 = (p1_n2[34] != p1_ctx.a[31]);
      end
      qrs_pkg::KIND_REPEAT: begin
        m1   = 34'(bmag);
        m2   = '0;
        den  = {amag, 1'b0};
        neg1 = (b_pos != p1_ctx.a[31]);
        neg2 = 1'b0;
      end
      qrs_pkg::KIND_COMPLEX: begin
        m1   = 34'(bmag);
        m2   = 34'(p1_s);
        den  = {amag, 1'b0};
        neg1 = (b_pos != p1_ctx.a[31]);
        neg2 = 1'b0;
      end
      default: begin
        m1   = '0;
        m2   = '0;
        den  = DEN_W'(1);
        neg1 = 1'b0;
        neg2 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p2_ctx  <= p1_ctx;
    p2_m1   <= m1;
    p2_m2   <= m2;
    p2_den  <= den;
    p2_neg1 <= neg1;
    p2_neg2 <= neg2;
  end

  // Prep stage 3: scale the numerators and add half the divisor for rounding.
  logic             p3_vld;
  qrs_pkg::ctx_t    p3_ctx;
  logic [NUM_W-1:0] p3_num1;
  logic [NUM_W-1:0] p3_num2;
  logic [DEN_W-1:0] p3_den;
  logic             p3_neg1;
  logic             p3_neg2;

  always_ff @(posedge clk) begin
    p3_ctx  <= p2_ctx;
    p3_num1 <= (NUM_W'(p2_m1) << FRAC_BITS) + NUM_W'(p2_den[DEN_W-1:1]);
    p3_num2 <= (NUM_W'(p2_m2) << FRAC_BITS) + NUM_W'(p2_den[DEN_W-1:1]);
    p3_den  <= p2_den;
    p3_neg1 <= p2_neg1;
    p3_neg2 <= p2_neg2;
  end

  // Two dividers run side by side; the first carries the context.
  logic             d1_vld;
  logic [NUM_W-1:0] d1_q;
  logic [CTX_W:0]   d1_tag;
  logic             d2_vld;
  logic [NUM_W-1:0] d2_q;
  logic             d2_tag;
  qrs_pkg::ctx_t    dv_ctx;
  logic             dv_neg1;

  qrs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .TAG_W (CTX_W + 1)
  ) u_div1 (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p3_vld),
    .num     (p3_num1),
    .den     (p3_den),
    .tag     ({p3_ctx, p3_neg1}),
    .out_vld (d1_vld),
    .quot    (d1_q),
    .out_tag (d1_tag)
  );

  qrs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .TAG_W (1)
  ) u_div2 (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p3_vld),
    .num     (p3_num2),
    .den     (p3_den),
    .tag     (p3_neg2),
    .out_vld (d2_vld),
    .quot    (d2_q),
    .out_tag (d2_tag)
  );

  assign {dv_ctx, dv_neg1} = d1_tag;

  // Quotient stage 1: detect overflow and clip the magnitudes.
  logic          q1_vld;
  qrs_pkg::ctx_t q1_ctx;
  logic [31:0]   q1_mag1;
  logic [31:0]   q1_mag2;
  logic          q1_neg1;
  logic          q1_neg2;
  logic          q1_sat;
  logic          sat1;
  logic          sat2;
  logic          two_vals;

  always_comb begin
    if (dv_neg1) begin
      sat1 = (|d1_q[NUM_W-1:32]) || (d1_q[31] && (|d1_q[30:0]));
    end else begin
      sat1 = |d1_q[NUM_W-1:31];
    end
    if (d2_tag) begin
      sat2 = (|d2_q[NUM_W-1:32]) || (d2_q[31] && (|d2_q[30:0]));
    end else begin
      sat2 = |d2_q[NUM_W-1:31];
    end
    two_vals = (dv_ctx.kind == qrs_pkg::KIND_TWO) || (dv_ctx.kind == qrs_pkg::KIND_COMPLEX);
  end

  always_ff @(posedge clk) begin
    q1_ctx  <= dv_ctx;
    q1_neg1 <= dv_neg1;
    q1_neg2 <= d2_tag;
    q1_mag1 <= sat1 ? (dv_neg1 ? 32'h8000_0000 : 32'h7FFF_FFFF) : d1_q[31:0];
    q1_mag2 <= sat2 ? (d2_tag ? 32'h8000_0000 : 32'h7FFF_FFFF) : d2_q[31:0];
    q1_sat  <= ((dv_ctx.kind != qrs_pkg::KIND_NONE) && sat1) || (two_vals && sat2);
  end

  // Quotient stage 2: apply signs and zero the fields a kind does not use.
  logic               q2_vld;
  qrs_pkg::ctx_t      q2_ctx;
  logic signed [31:0] q2_x [2];
  logic               q2_sat;

  always_ff @(posedge clk) begin
    q2_ctx <= q1_ctx;
    q2_sat <= q1_sat;
    if (q1_ctx.kind == qrs_pkg::KIND_NONE) begin
      q2_x[0] <= '0;
    end else begin
      q2_x[0] <= q1_neg1 ? -q1_mag1 : q1_mag1;
    end
    if ((q1_ctx.kind == qrs_pkg::KIND_TWO) || (q1_ctx.kind == qrs_pkg::KIND_COMPLEX)) begin
      q2_x[1] <= q1_neg2 ? -q1_mag2 : q1_mag2;
    end else begin
      q2_x[1] <= '0;
    end
  end

  // Residual check stages for both roots: R = a*x*x + b*x*2^F + c*2^2F.
  logic               c1_vld;
  logic               c2_vld;
  logic               c3_vld;
  logic               c4_vld;
  qrs_pkg::res_t      c1_res;
  qrs_pkg::res_t      c2_res;
  qrs_pkg::res_t      c3_res;
  qrs_pkg::res_t      c4_res;
  logic signed [31:0] c1_c;
  logic signed [31:0] c2_c;
  logic signed [31:0] c1_x   [2];
  logic signed [63:0] c1_ax  [2];
  logic signed [63:0] c1_bx  [2];
  logic signed [63:0] c2_phi [2];
  logic signed [64:0] c2_plo [2];
  logic signed [63:0] c2_bx  [2];
  logic signed [RW-1:0] c3_axx [2];
  logic signed [RW-1:0] c3_bcs [2];
  logic signed [RW-1:0] c4_r   [2];
  logic signed [RW-1:0] lim;
  logic signed [RW-1:0] low_sum [2];
  logic               fail [2];

  always_ff @(posedge clk) begin
    c1_res.kind <= q2_ctx.kind;
    c1_res.v1   <= q2_x[0];
    c1_res.v2   <= q2_x[1];
    c1_res.sat  <= q2_sat;
    c1_c        <= q2_ctx.c;
    c2_res      <= c1_res;
    c2_c        <= c1_c;
    c3_res      <= c2_res;
    c4_res      <= c3_res;
    for (int i = 0; i < 2; i++) begin
      // Products a*x and b*x.
      c1_x[i]   <= q2_x[i];
      c1_ax[i]  <= q2_ctx.a * q2_x[i];
      c1_bx[i]  <= q2_ctx.b * q2_x[i];
      // a*x*x as two 32 bit partial products.
      c2_phi[i] <= $signed(c1_ax[i][63:32]) * c1_x[i];
      c2_plo[i] <= $signed({1'b0, c1_ax[i][31:0]}) * c1_x[i];
      c2_bx[i]  <= c1_bx[i];
      // Align the terms.
      c3_axx[i] <= (RW'(c2_phi[i]) <<< 32) + RW'(c2_plo[i]);
      c3_bcs[i] <= (RW'(c2_bx[i]) <<< FRAC_BITS) + (RW'(c2_c) <<< (2 * FRAC_BITS));
      // Full residual.
      c4_r[i]   <= c3_axx[i] + c3_bcs[i];
    end
  end

  // Compare |R| with the tolerance scaled to 3F fraction bits.
  always_comb begin
    lim = $signed(RW'(tol) << (2 * FRAC_BITS));
    for (int i = 0; i < 2; i++) begin
      low_sum[i] = c4_r[i] + lim;
      fail[i]    = (c4_r[i] > lim) || low_sum[i][RW-1];
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    root_kind           <= c4_res.kind;
    first_value         <= c4_res.v1;
    second_value        <= c4_res.v2;
    saturated           <= c4_res.sat;
    first_check_failed  <= fail[0] && ((c4_res.kind == qrs_pkg::KIND_TWO) ||
                                       (c4_res.kind == qrs_pkg::KIND_REPEAT));
    second_check_failed <= fail[1] && (c4_res.kind == qrs_pkg::KIND_TWO);
  end

  // Valid bits for the stages outside the generated pipelines.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
      c4_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      p1_vld <= sq_vld[SQ_N];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      q1_vld <= d1_vld;
      q2_vld <= q1_vld;
      c1_vld <= q2_vld;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
      c4_vld <= c3_vld;
      done   <= c4_vld;
    end
  end

  // The two dividers stay in lock step.
  assert property (@(posedge clk) disable iff (rst) d1_vld == d2_vld)
    else $error("divider valid bits disagree");

  // Every accepted request gives a result after the pipeline latency.
  assert property (@(posedge clk) disable iff (rst) accept |-> ##LAT done)
    else $error("result missing after pipeline latency");

  // An unsolvable set reports all zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (done && (root_kind == qrs_pkg::KIND_NONE)) |->
      (first_value == '0) && (second_value == '0) && !saturated &&
      !first_check_failed && !second_check_failed)
    else $error("unsolvable result has nonzero fields");

  // A complex pair has a nonnegative imaginary part and no residual check.
  assert property (@(posedge clk) disable iff (rst)
    (done && (root_kind == qrs_pkg::KIND_COMPLEX)) |->
      !second_value[31] && !first_check_failed && !second_check_failed)
    else $error("complex result malformed");

  // The first check flag only rises for real quadratic roots.
  assert property (@(posedge clk) disable iff (rst)
    (done && first_check_failed) |->
      ((root_kind == qrs_pkg::KIND_TWO) || (root_kind == qrs_pkg::KIND_REPEAT)))
    else $error("check flag set for a kind without residual check");

endmodule

/* tb/quadratic_root_solver_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quadratic root solver: directed table, then random requests.
module quadratic_root_solver_tb;

  localparam int F = qrs_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_REQUESTS = 1330;
  localparam int DRAIN_CYCLES = 130;

  // One solver result as it appears on the result ports.
  typedef struct packed {
    qrs_pkg::kind_t     kind;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               f1;
    logic               f2;
    logic               sat;
  } root_res_t;

  // One row of the directed table; exp is used only where typed is set.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        typed;
    root_res_t   exp;
  } dir_row_t;

  localparam int N_DIR = 18;
  localparam root_res_t NONE_RES =
    '{qrs_pkg::KIND_NONE, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] coef_a = '0;
  logic signed [31:0] coef_b = '0;
  logic signed [31:0] coef_c = '0;
  logic cfg_write = 1'b0;
  logic [qrs_pkg::TOL_W-1:0] cfg_data = '0;
  logic done;
  logic [2:0] root_kind;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic first_check_failed;
  logic second_check_failed;
  logic saturated;

  root_res_t expected_roots[$];
  logic [qrs_pkg::TOL_W-1:0] tol_shadow = 1;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int kind_count[5] = '{0, 0, 0, 0, 0};
  int unexpected = 0;

  // Directed rows: extremes of each coefficient, each root kind, and saturation.
  dir_row_t dir_rows[N_DIR] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, NONE_RES},
    '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, NONE_RES},
    '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, NONE_RES},
    '{32'h0000_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b1,
      '{qrs_pkg::KIND_LINEAR, 32'sh0002_0000, 32'sd0, 1'b0, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1,
      '{qrs_pkg::KIND_LINEAR, 32'sh8000_0000, 32'sd0, 1'b0, 1'b0, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 1'b1,
      '{qrs_pkg::KIND_LINEAR, 32'sh7FFF_FFFF, 32'sd0, 1'b0, 1'b0, 1'b1}},
    '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE_RES},
    '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1,
      '{qrs_pkg::KIND_REPEAT, -32'sh0001_0000, 32'sd0, 1'b0, 1'b0, 1'b0}},
    '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1,
      '{qrs_pkg::KIND_COMPLEX, 32'sd0, 32'sh0001_0000, 1'b0, 1'b0, 1'b0}},
    '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b1,
      '{qrs_pkg::KIND_TWO, 32'sh0001_0000, -32'sh0001_0000, 1'b0, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE_RES},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE_RES},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE_RES},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE_RES},
    '{32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, NONE_RES},
    '{32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, NONE_RES},
    '{32'hFFFF_FFFF, 32'h0000_0003, 32'h8000_0000, 1'b0, NONE_RES},
    '{32'h0003_0000, 32'hFFF9_0000, 32'h0002_0000, 1'b0, NONE_RES}
  };

  quadratic_root_solver dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .coef_a(coef_a),
    .coef_b(coef_b),
    .coef_c(coef_c),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .root_kind(root_kind),
    .first_value(first_value),
    .second_value(second_value),
    .first_check_failed(first_check_failed),
    .second_check_failed(second_check_failed),
    .saturated(saturated)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Floor of the square root of a nonnegative value below 2^68, passed in 128 bits.
  function automatic longint floor_sqrt(input logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int bit_i = 33; bit_i >= 0; bit_i--) begin
      t = r | (128'd1 << bit_i);
      if (t * t <= d) r = t;
    end
    return longint'(r[63:0]);
  endfunction

  // Rounded quotient with the sign applied; bit 32 of the return is the clip flag.
  function automatic logic [32:0] round_div(input logic [63:0] num, input bit neg,
                                            input logic [63:0] den);
    logic [63:0] q;
    q = (num + den / 2) / den;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
    end
    if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'(-q)};
  endfunction

  // True when the root x, put back into the equation, misses by more than the tolerance.
  function automatic bit residual_over(input longint a, input longint b, input longint c,
                                       input longint x,
                                       input logic [qrs_pkg::TOL_W-1:0] tol);
    logic signed [127:0] la;
    logic signed [127:0] lb;
    logic signed [127:0] lc;
    logic signed [127:0] lx;
    logic signed [127:0] r;
    logic signed [127:0] lim;
    la = a;
    lb = b;
    lc = c;
    lx = x;
    r = la * lx * lx + ((lb * lx) <<< F) + (lc <<< (2 * F));
    if (r < 0) r = -r;
    lim = {97'd0, tol};
    lim = lim <<< (2 * F);
    return r > lim;
  endfunction

  // Predicts the solver's answer for one coefficient set.
  function automatic root_res_t solve_roots(input logic signed [31:0] ca,
                                            input logic signed [31:0] cb,
                                            input logic signed [31:0] cc,
                                            input logic [qrs_pkg::TOL_W-1:0] tol);
    root_res_t res;
    longint a;
    longint b;
    longint c;
    longint s;
    longint n1;
    longint n2;
    logic [63:0] den;
    logic signed [127:0] d;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] wc;
    logic [32:0] q1;
    logic [32:0] q2;
    a = ca;
    b = cb;
    c = cc;
    res = NONE_RES;
    q1 = '0;
    q2 = '0;
    if (a == 0) begin
      if (b != 0) begin
        res.kind = qrs_pkg::KIND_LINEAR;
        q1 = round_div(magnitude(c) << F, (c > 0) != (b < 0), magnitude(b));
      end
    end else begin
      den = 2 * magnitude(a);
      wa = a;
      wb = b;
      wc = c;
      d = wb * wb - 4 * wa * wc;
      if (d < 0) begin
        res.kind = qrs_pkg::KIND_COMPLEX;
        s = floor_sqrt(-d);
        q1 = round_div(magnitude(b) << F, (b > 0) != (a < 0), den);
        q2 = round_div(64'(s) << F, 1'b0, den);
      end else if (d == 0) begin
        res.kind = qrs_pkg::KIND_REPEAT;
        q1 = round_div(magnitude(b) << F, (b > 0) != (a < 0), den);
        res.f1 = residual_over(a, b, c, longint'($signed(q1[31:0])), tol);
      end else begin
        res.kind = qrs_pkg::KIND_TWO;
        s = floor_sqrt(d);
        n1 = -b + s;
        n2 = -b - s;
        q1 = round_div(magnitude(n1) << F, (n1 < 0) != (a < 0), den);
        q2 = round_div(magnitude(n2) << F, (n2 < 0) != (a < 0), den);
        res.f1 = residual_over(a, b, c, longint'($signed(q1[31:0])), tol);
        res.f2 = residual_over(a, b, c, longint'($signed(q2[31:0])), tol);
      end
    end
    res.v1 = q1[31:0];
    res.v2 = q2[31:0];
    res.sat = q1[32] | q2[32];
    return res;
  endfunction

  // Presents one request and, once it is taken, records its expected result.
  task automatic issue_request(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input bit typed,
                               input root_res_t typed_res);
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    do @(posedge clk); while (busy);
    if (typed) expected_roots.push_back(typed_res);
    else expected_roots.push_back(solve_roots(a, b, c, tol_shadow));
    requests_sent++;
  endtask

  // Random gap between requests, taken after about 30 requests in a hundred when allowed.
  task automatic maybe_idle(input bit allow);
    int gap;
    if (allow && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes the tolerance once all results are back.
  task automatic set_tolerance(input logic [qrs_pkg::TOL_W-1:0] value);
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    tol_shadow = value;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random coefficient set: mostly shaped equations, some raw noise.
  task automatic random_request(input bit allow_idle);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    int p;
    int m;
    int r1;
    int r2;
    case ($urandom_range(0, 9))
      0, 1: begin
        a = $urandom();
        b = $urandom();
        c = $urandom();
      end
      2: begin
        a = '0;
        b = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
        c = $urandom();
      end
      3, 4: begin
        // Repeated root: a = p, b = 2pm, c = pm^2.
        p = $urandom_range(1, 255);
        m = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) p = -p;
        if ($urandom_range(0, 1)) m = -m;
        a = p;
        b = 2 * p * m;
        c = p * m * m;
      end
      5, 6, 7: begin
        // Two chosen roots in raw units.
        p = $urandom_range(1, 255);
        r1 = $signed($urandom_range(0, 511)) - 256;
        r2 = $signed($urandom_range(0, 511)) - 256;
        if ($urandom_range(0, 1)) p = -p;
        a = p;
        b = -p * (r1 + r2);
        c = p * r1 * r2;
      end
      default: begin
        // Small Q16.16 values around unity.
        a = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        b = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        c = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      end
    endcase
    issue_request(a, b, c, 1'b0, NONE_RES);
    maybe_idle(allow_idle);
  endtask

  // Result checker: each strobed result against the oldest expectation.
  always @(posedge clk) begin
    root_res_t got;
    root_res_t want;
    if (!rst && done) begin
      got = '{qrs_pkg::kind_t'(root_kind), first_value, second_value, first_check_failed,
              second_check_failed, saturated};
      results_seen++;
      if (expected_roots.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with none expected: %p", $realtime, got);
      end else begin
        want = expected_roots.pop_front();
        if (want.kind <= qrs_pkg::KIND_COMPLEX) kind_count[want.kind]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: expected kind %0d v1 %h v2 %h f1 %b f2 %b sat %b, ",
                      "got kind %0d v1 %h v2 %h f1 %b f2 %b sat %b"},
                     $realtime, want.kind, want.v1, want.v2, want.f1, want.f2, want.sat,
                     got.kind, got.v1, got.v2, got.f1, got.f2, got.sat);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases over several tolerances.
  initial begin
    int drain;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      issue_request(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].typed,
                    dir_rows[i].exp);
      maybe_idle(1'b1);
    end
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_tolerance(31'd0);
        1: set_tolerance(31'h7FFF_FFFF);
        2: set_tolerance(31'd1);
        3: set_tolerance(31'(($urandom() & 32'hFFFF) + 1));
        default: set_tolerance(31'($urandom()));
      endcase
      for (int i = 0; i < RANDOM_REQUESTS / 5; i++)
        random_request(!(phase == 2 && i >= 40 && i < 240));
    end
    start <= 1'b0;
    drain = 0;
    while (expected_roots.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over five tolerance settings; %0d results checked.",
             requests_sent, results_seen);
    $display({"Kinds seen: none %0d, linear %0d, two %0d, repeated %0d, ",
              "complex %0d; %0d mismatches."},
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             mismatches);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding.", expected_roots.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
